// ----- design/double_array_trie_engine_top_defines.svh -----
// Assertion macros for the double-array trie engine.
// Used by the top level; the enclosing module supplies clk and rst_n.
`ifndef DOUBLE_ARRAY_TRIE_ENGINE_TOP_DEFINES_SVH
`define DOUBLE_ARRAY_TRIE_ENGINE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define DAT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define DAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DAT_ASSERT_IMPL(lbl, ante, cons, msg)
`define DAT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- design/dat_pkg.sv -----
// Shared constants, op codes, sequencer states and write-enable struct.
// No dependencies.
`default_nettype none
package dat_pkg;
  localparam int TRIE_SLOTS_DEF    = 65536;
  localparam int ALPHABET_SIZE_DEF = 27;
  localparam int OP_W  = 2;
  localparam int SYM_W = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_WORD   = 2'd1;
  localparam logic [OP_W-1:0] OP_PREFIX = 2'd2;

  typedef enum logic [18:0] {
    S_CLR   = 19'h00001,
    S_IDLE  = 19'h00002,
    S_RB    = 19'h00004,
    S_RT    = 19'h00008,
    S_CT    = 19'h00010,
    S_KRD   = 19'h00020,
    S_KCK   = 19'h00040,
    S_NINC  = 19'h00080,
    S_NRD   = 19'h00100,
    S_NCK   = 19'h00200,
    S_MSET  = 19'h00400,
    S_MRD   = 19'h00800,
    S_MCP   = 19'h01000,
    S_GRD   = 19'h02000,
    S_GCK   = 19'h04000,
    S_MFREE = 19'h08000,
    S_PRD   = 19'h10000,
    S_PCK   = 19'h20000,
    S_FIN   = 19'h40000
  } dat_state_t;

  typedef struct packed {
    logic base_we;
    logic par_we;
  } dat_wen_t;
endpackage
`default_nettype wire

// ----- design/dat_if.sv -----
// Valid/ready channel interfaces for symbol words and result words.
// Depends on dat_pkg.
`default_nettype none
interface dat_in_if import dat_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [SYM_W-1:0] symbol;
  logic             last;
  modport source (output valid, op, symbol, last, input ready);
  modport sink (input valid, op, symbol, last, output ready);
endinterface

interface dat_out_if;
  logic valid;
  logic ready;
  logic found;
  logic out_of_space;
  modport source (output valid, found, out_of_space, input ready);
  modport sink (input valid, found, out_of_space, output ready);
endinterface
`default_nettype wire

// ----- design/dat_mem.sv -----
// Base and parent memories, one shared registered read address, one write address.
// Depends on dat_pkg.
`default_nettype none
module dat_mem import dat_pkg::*; #(
  parameter int TRIE_SLOTS = TRIE_SLOTS_DEF,
  parameter int AW = $clog2(TRIE_SLOTS)
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] ra,
  input  wire logic [AW-1:0] wa,
  input  wire dat_wen_t      wen,
  input  wire logic [AW-1:0] wd_b,
  input  wire logic [AW:0]   wd_p,
  output logic      [AW-1:0] base_q,
  output logic      [AW:0]   par_q
);
  logic [AW-1:0] base_mem [TRIE_SLOTS];
  logic [AW:0]   par_mem  [TRIE_SLOTS];

  always_ff @(posedge clk) begin
    if (wen.base_we) base_mem[wa] <= wd_b;
    base_q <= base_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (wen.par_we) par_mem[wa] <= wd_p;
    par_q <= par_mem[ra];
  end
endmodule
`default_nettype wire

// ----- design/double_array_trie_engine_top.sv -----
// Double-array trie engine: sequencer over base/parent memories.
// Depends on dat_pkg, dat_if, dat_mem and the assertion macro header.
//
//   channel  dir  words                 accepted when
//   in_if    in   op, symbol, last      valid && ready
//   out_if   out  found, out_of_space   valid && ready
//
// A symbol runs through accept, base read, parent read, check and finish;
// the end marker adds another base read, parent read and check. An insert
// on a free slot costs the same. Each step costs two dependent single-port
// memory reads. A collision adds a child scan over every code, a base search
// (checking each child's code and the new code per candidate base) and a
// move of each child with its grandchildren.
// After reset a pass clears all TRIE_SLOTS slots before input is taken.
// A result waits in its output register; the next word is taken meanwhile.
`default_nettype none
`include "double_array_trie_engine_top_defines.svh"
module double_array_trie_engine_top import dat_pkg::*; #(
  parameter int TRIE_SLOTS    = TRIE_SLOTS_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  dat_in_if.sink   in_if,
  dat_out_if.source out_if
);
  localparam int AW = $clog2(TRIE_SLOTS);
  localparam int SW = AW + 1;
  localparam int JW = $clog2(ALPHABET_SIZE + 2);
  localparam logic [SW-1:0] SLOTS_X = SW'(TRIE_SLOTS);
  localparam logic [SW-1:0] FREE = {SW{1'b1}};
  localparam logic [JW-1:0] CEND = JW'(ALPHABET_SIZE);
  localparam logic [JW-1:0] JEND = JW'(ALPHABET_SIZE + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(TRIE_SLOTS - 1);

  dat_state_t st_r, st_nxt;
  logic [OP_W-1:0] op_r, op_nxt;
  logic last_r, last_nxt, endp_r, endp_nxt;
  logic [JW-1:0] code_r, code_nxt, j_r, j_nxt, k_r, k_nxt, kmax_r, kmax_nxt;
  logic [AW-1:0] cur_r, cur_nxt, ob_r, ob_nxt, t_r, t_nxt, nb_r, nb_nxt;
  logic [AW-1:0] gb_r, gb_nxt, clr_r, clr_nxt;
  logic miss_r, miss_nxt, err_r, err_nxt;
  logic [2**JW-1:0] kid_r, kid_nxt;
  logic out_valid_r, out_valid_nxt, out_found_r, out_found_nxt, out_oos_r, out_oos_nxt;

  logic [AW-1:0] ra, wa, wd_b, base_q;
  logic [SW-1:0] wd_p, par_q;
  dat_wen_t wen;

  dat_mem #(.TRIE_SLOTS(TRIE_SLOTS), .AW(AW)) u_mem (
    .clk(clk), .ra(ra), .wa(wa), .wen(wen), .wd_b(wd_b), .wd_p(wd_p),
    .base_q(base_q), .par_q(par_q)
  );

  function automatic logic [SW-1:0] slot_sum(input logic [AW-1:0] b, input logic [JW-1:0] c);
    return SW'(b) + SW'(c);
  endfunction

  logic ins;
  logic [SW-1:0] s;
  logic [SW-1:0] nb_inc;
  logic [JW-1:0] mx;
  logic out_free;

  assign ins = (op_r == OP_INSERT);
  assign in_if.ready = (st_r == S_IDLE);
  assign out_if.valid = out_valid_r;
  assign out_if.found = out_found_r;
  assign out_if.out_of_space = out_oos_r;

  always_comb begin
    st_nxt = st_r; op_nxt = op_r; last_nxt = last_r; endp_nxt = endp_r;
    code_nxt = code_r; j_nxt = j_r; k_nxt = k_r; kmax_nxt = kmax_r;
    cur_nxt = cur_r; ob_nxt = ob_r; t_nxt = t_r; nb_nxt = nb_r; gb_nxt = gb_r;
    clr_nxt = clr_r; miss_nxt = miss_r; err_nxt = err_r; kid_nxt = kid_r;
    out_valid_nxt = out_valid_r; out_found_nxt = out_found_r; out_oos_nxt = out_oos_r;
    ra = '0; wa = '0; wd_b = '0; wd_p = '0; wen = '0;
    s = '0; nb_inc = '0; mx = '0;
    out_free = !out_valid_r || out_if.ready;
    if (out_valid_r && out_if.ready) out_valid_nxt = 1'b0;
    case (st_r)
      S_CLR: begin
        wen = '{base_we: 1'b1, par_we: 1'b1};
        wa = clr_r;
        wd_b = (clr_r == '0) ? AW'(1) : '0;
        wd_p = (clr_r == '0) ? '0 : FREE;
        if (clr_r == LAST_SLOT) st_nxt = S_IDLE;
        else clr_nxt = clr_r + AW'(1);
      end
      S_IDLE: begin
        if (in_if.valid) begin
          op_nxt = in_if.op;
          last_nxt = in_if.last;
          code_nxt = JW'(in_if.symbol);
          endp_nxt = 1'b0;
          if (miss_r || err_r) begin
            st_nxt = S_FIN;
          end else if (in_if.symbol == '0 || int'(in_if.symbol) > ALPHABET_SIZE) begin
            miss_nxt = 1'b1;
            st_nxt = S_FIN;
          end else begin
            st_nxt = S_RB;
          end
        end
      end
      S_RB: begin
        ra = cur_r;
        st_nxt = S_RT;
      end
      S_RT: begin
        ob_nxt = base_q;
        s = slot_sum(base_q, code_r);
        if (s >= SLOTS_X) begin
          if (ins) err_nxt = 1'b1;
          else miss_nxt = 1'b1;
          st_nxt = S_FIN;
        end else begin
          t_nxt = s[AW-1:0];
          ra = s[AW-1:0];
          st_nxt = S_CT;
        end
      end
      S_CT, S_PCK: begin
        if (ins && par_q == FREE) begin
          wen = '{base_we: 1'b1, par_we: 1'b1};
          wa = t_r;
          wd_b = AW'(1);
          wd_p = SW'(cur_r);
        end
        if (st_r == S_CT && ins && par_q != FREE && par_q != SW'(cur_r)) begin
          j_nxt = JW'(1);
          kmax_nxt = '0;
          kid_nxt = '0;
          st_nxt = S_KRD;
        end else if (st_r == S_CT && !ins && par_q != SW'(cur_r)) begin
          miss_nxt = 1'b1;
          st_nxt = S_FIN;
        end else begin
          cur_nxt = t_r;
          if (last_r && !endp_r && (ins || op_r == OP_WORD)) begin
            endp_nxt = 1'b1;
            code_nxt = CEND;
            st_nxt = S_RB;
          end else begin
            st_nxt = S_FIN;
          end
        end
      end
      S_KRD: begin
        if (j_r == JEND) begin
          nb_nxt = ob_r;
          st_nxt = S_NINC;
        end else begin
          s = slot_sum(ob_r, j_r);
          if (s < SLOTS_X) begin
            ra = s[AW-1:0];
            st_nxt = S_KCK;
          end else begin
            j_nxt = j_r + JW'(1);
          end
        end
      end
      S_KCK: begin
        if (par_q == SW'(cur_r)) begin
          kid_nxt[j_r] = 1'b1;
          kmax_nxt = j_r;
        end
        j_nxt = j_r + JW'(1);
        st_nxt = S_KRD;
      end
      S_NINC: begin
        nb_inc = SW'(nb_r) + SW'(1);
        mx = (kmax_r > code_r) ? kmax_r : code_r;
        s = nb_inc + SW'(mx);
        if (s >= SLOTS_X) begin
          err_nxt = 1'b1;
          st_nxt = S_FIN;
        end else begin
          nb_nxt = nb_inc[AW-1:0];
          j_nxt = JW'(1);
          st_nxt = S_NRD;
        end
      end
      S_NRD: begin
        if (j_r == JEND) begin
          st_nxt = S_MSET;
        end else if (kid_r[j_r] || j_r == code_r) begin
          s = slot_sum(nb_r, j_r);
          ra = s[AW-1:0];
          st_nxt = S_NCK;
        end else begin
          j_nxt = j_r + JW'(1);
        end
      end
      S_NCK: begin
        if (par_q != FREE) begin
          st_nxt = S_NINC;
        end else begin
          j_nxt = j_r + JW'(1);
          st_nxt = S_NRD;
        end
      end
      S_MSET: begin
        wen.base_we = 1'b1;
        wa = cur_r;
        wd_b = nb_r;
        j_nxt = JW'(1);
        st_nxt = S_MRD;
      end
      S_MRD: begin
        if (j_r == JEND) begin
          s = slot_sum(nb_r, code_r);
          t_nxt = s[AW-1:0];
          st_nxt = S_PRD;
        end else if (kid_r[j_r]) begin
          s = slot_sum(ob_r, j_r);
          ra = s[AW-1:0];
          st_nxt = S_MCP;
        end else begin
          j_nxt = j_r + JW'(1);
        end
      end
      S_MCP: begin
        gb_nxt = base_q;
        s = slot_sum(nb_r, j_r);
        wen = '{base_we: 1'b1, par_we: 1'b1};
        wa = s[AW-1:0];
        wd_b = base_q;
        wd_p = SW'(cur_r);
        if (base_q != '0) begin
          k_nxt = JW'(1);
          st_nxt = S_GRD;
        end else begin
          st_nxt = S_MFREE;
        end
      end
      S_GRD: begin
        if (k_r == JEND) begin
          st_nxt = S_MFREE;
        end else begin
          s = slot_sum(gb_r, k_r);
          if (s < SLOTS_X) begin
            ra = s[AW-1:0];
            st_nxt = S_GCK;
          end else begin
            k_nxt = k_r + JW'(1);
          end
        end
      end
      S_GCK: begin
        if (par_q == slot_sum(ob_r, j_r)) begin
          s = slot_sum(gb_r, k_r);
          wen.par_we = 1'b1;
          wa = s[AW-1:0];
          wd_p = slot_sum(nb_r, j_r);
        end
        k_nxt = k_r + JW'(1);
        st_nxt = S_GRD;
      end
      S_MFREE: begin
        s = slot_sum(ob_r, j_r);
        wen = '{base_we: 1'b1, par_we: 1'b1};
        wa = s[AW-1:0];
        wd_b = '0;
        wd_p = FREE;
        j_nxt = j_r + JW'(1);
        st_nxt = S_MRD;
      end
      S_PRD: begin
        ra = t_r;
        st_nxt = S_PCK;
      end
      S_FIN: begin
        if (!last_r) begin
          st_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = !miss_r && !err_r;
          out_oos_nxt = err_r;
          cur_nxt = '0;
          miss_nxt = 1'b0;
          err_nxt = 1'b0;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      clr_r <= '0;
      cur_r <= '0;
      miss_r <= 1'b0;
      err_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      clr_r <= clr_nxt;
      cur_r <= cur_nxt;
      miss_r <= miss_nxt;
      err_r <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; last_r <= last_nxt; endp_r <= endp_nxt; code_r <= code_nxt;
    j_r <= j_nxt; k_r <= k_nxt; kmax_r <= kmax_nxt; ob_r <= ob_nxt; t_r <= t_nxt;
    nb_r <= nb_nxt; gb_r <= gb_nxt; kid_r <= kid_nxt;
    out_found_r <= out_found_nxt; out_oos_r <= out_oos_nxt;
  end

  `DAT_ASSERT_IMPL(a_move_up, st_r == S_MSET, nb_r > ob_r, "relocation base not above old base")
  `DAT_ASSERT_NEXT(a_accept_busy, in_if.valid && in_if.ready, st_r != S_IDLE, "accept left idle")
  `DAT_ASSERT_IMPL(a_claim_free, st_r == S_PCK && wen.par_we, par_q == FREE, "claimed used slot")
  `DAT_ASSERT_IMPL(a_cur_range, st_r != S_CLR, SW'(cur_r) < SLOTS_X, "node out of range")
endmodule
`default_nettype wire
